/* sv/mstg_pkg.sv */
// Shared types, constants and codes for the multichannel square tone generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mstg_pkg;

    localparam int MAX_CH_DEF = 8;
    localparam int FUNC_W     = 2;
    localparam int CH_W       = 3;
    localparam int FREQ_W     = 16;
    localparam int COUNT_W    = 11;
    localparam int TONE_W     = 8;
    localparam int INUSE_W    = 4;
    localparam int USE_W      = 5;
    localparam int NUM_W      = FREQ_W + 1;
    localparam int Q_DEPTH    = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [FREQ_W-1:0]  RATE_RESET = 16'd8000;
    localparam logic [FREQ_W-1:0]  MIN_FREQ   = 16'd60;
    localparam logic [INUSE_W-1:0] CHANS_RESET = 4'd0;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SETF = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ON   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_OFF  = 2'd3;

    // Register indexes.
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_CHANS = 1'b1;

    typedef logic [2:0] t_op;

    // Classified operations handed from the front to the back.
    localparam t_op OP_TICK    = 3'd0;
    localparam t_op OP_SETF    = 3'd1;
    localparam t_op OP_SILENCE = 3'd2;
    localparam t_op OP_ENABLE  = 3'd3;
    localparam t_op OP_DISABLE = 3'd4;
    localparam t_op OP_IGNORE  = 3'd5;

    typedef struct packed {
        t_op               op;
        logic [CH_W-1:0]   ch;
        logic [FREQ_W-1:0] freq;
        logic [NUM_W-1:0]  numer;
    } t_cmd;

endpackage

/* sv/mstg_front.sv */
// Front end: accepts transactions and classifies them into back-end commands.
// Depends on mstg_pkg.
module mstg_front (
    input  logic                         start,
    input  logic [mstg_pkg::FUNC_W-1:0]  i_func,
    input  logic [mstg_pkg::CH_W-1:0]    i_channel,
    input  logic [mstg_pkg::FREQ_W-1:0]  i_frequency,
    input  logic [mstg_pkg::FREQ_W-1:0]  i_rate,
    input  logic [mstg_pkg::USE_W-1:0]   i_lim,
    input  logic                         i_full,
    output logic                         o_push,
    output mstg_pkg::t_cmd               o_cmd
);
    import mstg_pkg::*;

    logic w_out_of_range;

    assign o_push = start && !i_full;

    // Set-frequency requests below the floor or above half the master rate silence the channel.
    assign w_out_of_range = (i_frequency < MIN_FREQ) ||
                            (i_frequency > {1'b0, i_rate[FREQ_W-1:1]});

    always_comb begin
        o_cmd.ch    = i_channel;
        o_cmd.freq  = i_frequency;
        o_cmd.numer = {1'b0, i_rate} + {1'b0, i_frequency} - NUM_W'(1);
        unique case (i_func)
            FUNC_TICK: o_cmd.op = OP_TICK;
            FUNC_SETF: o_cmd.op = w_out_of_range ? OP_SILENCE : OP_SETF;
            FUNC_ON:   o_cmd.op = OP_ENABLE;
            default:   o_cmd.op = OP_DISABLE;
        endcase
        if (i_func != FUNC_TICK && {{(USE_W-CH_W){1'b0}}, i_channel} >= i_lim) begin
            o_cmd.op = OP_IGNORE;
        end
    end

endmodule

/* sv/mstg_queue.sv */
// Short command queue between the front end and the back end.
// Depends on mstg_pkg for the command type and depth.
module mstg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mstg_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output mstg_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import mstg_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* sv/mstg_back.sv */
// Back end: holds the channel state, executes commands and drives results.
// Set-frequency commands run an iterative restoring divider. Depends on mstg_pkg.
module mstg_back #(
    parameter int MAX_CHANNELS = mstg_pkg::MAX_CH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mstg_pkg::t_cmd              i_cmd,
    input  logic                        i_empty,
    input  logic [mstg_pkg::USE_W-1:0]  i_lim,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [mstg_pkg::TONE_W-1:0] o_tone_levels,
    output logic                        o_ignored
);
    import mstg_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;
    localparam int   STEP_W = $clog2(COUNT_W);
    localparam int   WIDE_W = (MAX_CHANNELS > TONE_W) ? MAX_CHANNELS : TONE_W;

    logic                    r_state, n_state;
    logic [COUNT_W-1:0]      r_count  [MAX_CHANNELS];
    logic [COUNT_W-1:0]      n_count  [MAX_CHANNELS];
    logic [COUNT_W-1:0]      r_period [MAX_CHANNELS];
    logic [COUNT_W-1:0]      n_period [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_enable, n_enable;
    logic [MAX_CHANNELS-1:0] r_active, n_active;
    logic [MAX_CHANNELS-1:0] r_level, n_level;
    logic [CH_W-1:0]         r_ch, n_ch;
    logic [FREQ_W-1:0]       r_freq, n_freq;
    logic [FREQ_W-1:0]       r_rem, n_rem;
    logic [COUNT_W-1:0]      r_nlow, n_nlow;
    logic [COUNT_W-1:0]      r_quo, n_quo;
    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_strobe, n_strobe;
    logic                    r_ignored, n_ignored;
    logic [TONE_W-1:0]       r_tone, n_tone;
    logic [NUM_W-1:0]        w_rem_sh;
    logic [NUM_W-1:0]        w_diff;
    logic                    w_ge;
    logic [WIDE_W-1:0]       w_level_wide;

    assign o_strobe      = r_strobe;
    assign o_tone_levels = r_tone;
    assign o_ignored     = r_ignored;

    // One quotient bit per cycle; the partial remainder always stays below the divisor.
    assign w_rem_sh = {r_rem, r_nlow[COUNT_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_freq};
    assign w_ge     = (w_rem_sh >= {1'b0, r_freq});

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_period  = r_period;
        n_enable  = r_enable;
        n_active  = r_active;
        n_level   = r_level;
        n_ch      = r_ch;
        n_freq    = r_freq;
        n_rem     = r_rem;
        n_nlow    = r_nlow;
        n_quo     = r_quo;
        n_step    = r_step;
        n_strobe  = 1'b0;
        n_ignored = r_ignored;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_TICK: begin
                            for (int i = 0; i < MAX_CHANNELS; i++) begin
                                if (USE_W'(i) < i_lim && r_active[i]) begin
                                    if (r_count[i] >= r_period[i]) begin
                                        n_count[i] = '0;
                                        n_level[i] = r_enable[i] ? ~r_level[i] : 1'b0;
                                    end else begin
                                        n_count[i] = r_count[i] + COUNT_W'(1);
                                    end
                                end
                            end
                            n_strobe  = 1'b1;
                            n_ignored = 1'b0;
                        end
                        OP_SETF: begin
                            n_state = S_DIV;
                            n_ch    = i_cmd.ch;
                            n_freq  = i_cmd.freq;
                            n_rem   = FREQ_W'(i_cmd.numer[NUM_W-1:COUNT_W]);
                            n_nlow  = i_cmd.numer[COUNT_W-1:0];
                            n_quo   = '0;
                            n_step  = '0;
                        end
                        OP_SILENCE: begin
                            for (int i = 0; i < MAX_CHANNELS; i++) begin
                                if ({{(USE_W-CH_W){1'b0}}, i_cmd.ch} == USE_W'(i)) begin
                                    n_count[i]  = '0;
                                    n_period[i] = '0;
                                    n_active[i] = 1'b0;
                                    n_level[i]  = 1'b0;
                                end
                            end
                            n_strobe  = 1'b1;
                            n_ignored = 1'b0;
                        end
                        OP_ENABLE, OP_DISABLE: begin
                            for (int i = 0; i < MAX_CHANNELS; i++) begin
                                if ({{(USE_W-CH_W){1'b0}}, i_cmd.ch} == USE_W'(i)) begin
                                    n_enable[i] = (i_cmd.op == OP_ENABLE);
                                end
                            end
                            n_strobe  = 1'b1;
                            n_ignored = 1'b0;
                        end
                        OP_IGNORE: begin
                            n_strobe  = 1'b1;
                            n_ignored = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem  = w_ge ? w_diff[FREQ_W-1:0] : w_rem_sh[FREQ_W-1:0];
                n_nlow = {r_nlow[COUNT_W-2:0], 1'b0};
                n_quo  = {r_quo[COUNT_W-2:0], w_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(COUNT_W - 1)) begin
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        if ({{(USE_W-CH_W){1'b0}}, r_ch} == USE_W'(i)) begin
                            n_count[i]  = '0;
                            n_period[i] = {r_quo[COUNT_W-2:0], w_ge};
                            n_active[i] = 1'b1;
                        end
                    end
                    n_strobe  = 1'b1;
                    n_ignored = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_level_wide = WIDE_W'(n_level);
    assign n_tone       = w_level_wide[TONE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enable  <= '0;
            r_active  <= '0;
            r_level   <= '0;
            r_strobe  <= 1'b0;
            r_ignored <= 1'b0;
            r_tone    <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_count[i]  <= '0;
                r_period[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_enable  <= n_enable;
            r_active  <= n_active;
            r_level   <= n_level;
            r_strobe  <= n_strobe;
            r_ignored <= n_ignored;
            r_tone    <= n_tone;
            r_count   <= n_count;
            r_period  <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_freq <= n_freq;
        r_rem  <= n_rem;
        r_nlow <= n_nlow;
        r_quo  <= n_quo;
        r_step <= n_step;
    end

endmodule

/* sv/multichannel_square_tone_generator.sv */
// Top level of the multichannel square tone generator: APB-style register port,
// front end, command queue and back end. Depends on mstg_pkg and the mstg_* modules.
//
// Usage: drive start with func, channel and frequency; the transaction is taken at a
// clock edge where start is high and busy is low. busy is high while the two-entry
// command queue is full. Every transaction produces exactly one result, shown on
// o_tone_levels and o_ignored for one cycle while o_strobe is high; the receiver
// cannot hold it off.
// A tick, enable, disable, ignored or out-of-range set-frequency transaction passes through
// the queue and the registered back-end outputs; a set-frequency transaction that loads a
// period also runs the eleven quotient steps of the one-bit-per-cycle back-end divider.
// Throughput: one transaction per cycle while busy is low and no period is being divided;
// during a division the queue lets the front keep taking transactions until it is full.
// Registers: master_tick_rate at byte address 0, channels_in_use at address 4. Write
// them only while no transaction is in flight. Reset clears all channel state, sets
// master_tick_rate to 8000 and channels_in_use to 0; no clearing pass is needed.
module multichannel_square_tone_generator #(
    parameter int MAX_CHANNELS = mstg_pkg::MAX_CH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mstg_pkg::FUNC_W-1:0]   i_func,
    input  logic [mstg_pkg::CH_W-1:0]     i_channel,
    input  logic [mstg_pkg::FREQ_W-1:0]   i_frequency,
    output logic                          o_strobe,
    output logic [mstg_pkg::TONE_W-1:0]   o_tone_levels,
    output logic                          o_ignored,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mstg_pkg::ADDR_W-1:0]   paddr,
    input  logic [mstg_pkg::DATA_W-1:0]   pwdata,
    output logic [mstg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mstg_pkg::*;

    logic [FREQ_W-1:0]  r_master_rate;
    logic [INUSE_W-1:0] r_chans;
    logic [USE_W-1:0]   w_lim;
    logic               w_wr;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    t_cmd               w_push_cmd;
    t_cmd               w_pop_cmd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign busy   = w_full;
    assign prdata = (paddr[ADDR_W-1] == REG_CHANS) ? DATA_W'(r_chans) : DATA_W'(r_master_rate);

    // A channel count above the number of channels built acts as all of them.
    assign w_lim = ({1'b0, r_chans} > USE_W'(MAX_CHANNELS)) ? USE_W'(MAX_CHANNELS)
                                                             : {1'b0, r_chans};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_rate <= RATE_RESET;
            r_chans       <= CHANS_RESET;
        end else if (w_wr) begin
            if (paddr[ADDR_W-1] == REG_RATE) begin
                r_master_rate <= pwdata[FREQ_W-1:0];
            end else begin
                r_chans <= pwdata[INUSE_W-1:0];
            end
        end
    end

    mstg_front u_front (
        .start       (start),
        .i_func      (i_func),
        .i_channel   (i_channel),
        .i_frequency (i_frequency),
        .i_rate      (r_master_rate),
        .i_lim       (w_lim),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    mstg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mstg_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_pop_cmd),
        .i_empty       (w_empty),
        .i_lim         (w_lim),
        .o_pop         (w_pop),
        .o_strobe      (o_strobe),
        .o_tone_levels (o_tone_levels),
        .o_ignored     (o_ignored)
    );

endmodule
